// ===== rtl/deq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue: opcodes, result
// status codes, and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int OP_W           = 3;
    localparam int ST_W           = 2;
    localparam int S_TDATA_W      = 32;
    localparam int S_TUSER_W      = 8;
    localparam int M_TDATA_W      = 32;
    localparam int M_TUSER_W      = 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST_FWD   = 3'd4,
        OP_LIST_REV   = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } st_t;

    typedef enum logic [1:0] {
        OUT_OK_ZERO = 2'd0,
        OUT_EMPTY   = 2'd1,
        OUT_FULL    = 2'd2,
        OUT_READ    = 2'd3
    } out_sel_t;

    typedef struct packed {
        logic     push_front;
        logic     push_back;
        logic     pop_front;
        logic     pop_back;
        logic     list_start;
        logic     list_rev;
        logic     list_next;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_last;
    } deq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic list_done;
        logic out_free;
    } deq_sts_t;

endpackage
`default_nettype wire

// ===== rtl/deq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller of the double-ended queue. Decodes each accepted item and
// sequences the memory reads of pops and read-outs.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    input  wire logic [OP_W-1:0] opcode,
    input  wire deq_sts_t        sts,
    output logic                 s_tready,
    output deq_cmd_t             cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE) && sts.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_OK_ZERO;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.out_last = 1'b1;
                    unique case (op_t'(opcode))
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            cmd.out_load = 1'b1;
                            if (sts.full) begin
                                cmd.out_sel = OUT_FULL;
                            end else begin
                                cmd.push_front = (op_t'(opcode) == OP_PUSH_FRONT);
                                cmd.push_back  = (op_t'(opcode) == OP_PUSH_BACK);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (sts.empty) begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = OUT_EMPTY;
                            end else begin
                                cmd.pop_front = (op_t'(opcode) == OP_POP_FRONT);
                                cmd.pop_back  = (op_t'(opcode) == OP_POP_BACK);
                                state_next    = S_EMIT;
                            end
                        end
                        OP_LIST_FWD, OP_LIST_REV: begin
                            if (sts.empty) begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = OUT_EMPTY;
                            end else begin
                                cmd.list_start = 1'b1;
                                cmd.list_rev   = (op_t'(opcode) == OP_LIST_REV);
                                state_next     = S_EMIT;
                            end
                        end
                        default: begin
                            cmd.out_last = 1'b0;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_READ;
                    cmd.out_last = sts.list_done;
                    if (sts.list_done) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.list_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/deq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_datapath
// Datapath of the double-ended queue: circular entry memory, front index,
// entry count, read-out position and the output register.
// ----------------------------------------------------------------------------
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [VALUE_W-1:0] value,
    input  wire deq_cmd_t           cmd,
    input  wire logic               m_tready,
    output deq_sts_t                sts,
    output logic                    m_tvalid,
    output logic [M_TDATA_W-1:0]    m_tdata,
    output logic [M_TUSER_W-1:0]    m_tuser,
    output logic                    m_tlast
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_S = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_reg;
    logic [IDX_W-1:0]      front_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      remain_reg;
    logic [IDX_W-1:0]      off_reg;
    logic                  rev_reg;
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;
    st_t                   out_st_reg;
    logic                  out_last_reg;

    logic [IDX_W-1:0]            count_ix;
    logic [IDX_W-1:0]            last_off;
    logic [IDX_W-1:0]            front_dec;
    logic [IDX_W-1:0]            back_slot;
    logic [IDX_W-1:0]            front_inc;
    logic [IDX_W-1:0]            next_off;
    logic [IDX_W-1:0]            rd_off;
    logic [IDX_W-1:0]            rd_addr;
    logic                        rd_en;
    logic [DATA_WIDTH+63:0]      wr_wide;
    logic [DATA_WIDTH-1:0]       wr_data;
    logic [DATA_WIDTH+31:0]      rd_wide;

    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    assign count_ix  = count_reg[IDX_W-1:0];
    assign last_off  = count_ix - 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IX : front_reg - 1'b1;
    assign back_slot = slot(front_reg, count_ix);
    assign front_inc = slot(front_reg, IDX_W'(1));
    assign next_off  = rev_reg ? off_reg - 1'b1 : off_reg + 1'b1;

    always_comb begin
        rd_off = next_off;
        if (cmd.pop_front) begin
            rd_off = '0;
        end else if (cmd.pop_back) begin
            rd_off = last_off;
        end else if (cmd.list_start) begin
            rd_off = cmd.list_rev ? last_off : '0;
        end
    end

    assign rd_addr = slot(front_reg, rd_off);
    assign rd_en   = cmd.pop_front || cmd.pop_back || cmd.list_start || cmd.list_next;
    assign wr_wide = {{DATA_WIDTH{1'b0}}, 32'b0, value};
    assign wr_data = wr_wide[DATA_WIDTH-1:0];
    assign rd_wide = {32'b0, rd_reg};

    always_ff @(posedge aclk) begin
        if (cmd.push_front) begin
            mem[front_dec] <= wr_data;
        end else if (cmd.push_back) begin
            mem[back_slot] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.push_front) begin
                front_reg <= front_dec;
                count_reg <= count_reg + 1'b1;
            end else if (cmd.push_back) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.pop_front || cmd.pop_back) begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1)) begin
                    front_reg <= '0;
                end else if (cmd.pop_front) begin
                    front_reg <= front_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop_front || cmd.pop_back) begin
            remain_reg <= '0;
        end else if (cmd.list_start) begin
            remain_reg <= count_reg - 1'b1;
            off_reg    <= rd_off;
            rev_reg    <= cmd.list_rev;
        end else if (cmd.list_next) begin
            remain_reg <= remain_reg - 1'b1;
            off_reg    <= next_off;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_last_reg <= cmd.out_last;
            out_data_reg <= '0;
            case (cmd.out_sel)
                OUT_EMPTY: out_st_reg <= ST_EMPTY;
                OUT_FULL:  out_st_reg <= ST_FULL;
                OUT_READ: begin
                    out_st_reg   <= ST_OK;
                    out_data_reg <= rd_wide[M_TDATA_W-1:0];
                end
                default:   out_st_reg <= ST_OK;
            endcase
        end
    end

    assign sts.full      = (count_reg == FULL_CNT);
    assign sts.empty     = (count_reg == '0);
    assign sts.list_done = (remain_reg == '0);
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {{(M_TUSER_W - ST_W){1'b0}}, out_st_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/double_ended_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of words with push, pop and read-out.
// ----------------------------------------------------------------------------
// Usage: each item on the s_ channel carries an opcode in s_tuser and a word
// in s_tdata. Results leave on the m_ channel with the word in m_tdata, the
// status (ok, empty, full) in m_tuser and tlast on the final result of an item.
// Pushes and results with a non-ok status appear in the cycle after acceptance
// and a new item can be taken every cycle while the receiver takes each result.
// A pop reads the entry memory into a read register, then loads its result
// into the output register, with s_tready low until then. A read-out gives its
// first word the same way and then one word per cycle while m_tready is high,
// set by the single read port of the entry memory; s_tready stays low until the
// final word is loaded into the output register. Opcodes six and seven are
// taken and give no result.
// When the receiver holds m_tready low, the output register keeps its item,
// s_tready falls and the read-out pauses without losing its place.
// Synchronous reset empties the queue and drops any pending result; the
// entry memory keeps its contents but is never read before it is written.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // [2:0] opcode
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // [31:0] data
    output logic [M_TUSER_W-1:0]      m_tuser,  // [1:0] status
    output logic                      m_tlast
);

    deq_cmd_t cmd;
    deq_sts_t sts;

    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .opcode   (s_tuser[OP_W-1:0]),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .value    (s_tdata[VALUE_W-1:0]),
        .cmd      (cmd),
        .m_tready (m_tready),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending item");

    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while the output register is blocked");

    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.full && sts.empty))
        else $error("queue reported full and empty at once");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule
`default_nettype wire
